FILE: rtl/core/periodic_volume_sampler_unit_macros.svh
// Assertion macros for the sampler's RTL; the query sequencer is the module that uses them.
`ifndef PERIODIC_VOLUME_SAMPLER_UNIT_MACROS_SVH
`define PERIODIC_VOLUME_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk and disabled in reset.
`define PVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and disabled in reset.
`define PVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pvs_pkg.sv
// Shared constants and types of the periodic volume sampler.
package pvs_pkg;

    localparam int DENSITY_BITS = 32;
    localparam int GRID_DIM_MAX = 64;
    localparam int LUT_MAX      = 1024;
    localparam int AXIS_W       = $clog2(GRID_DIM_MAX);
    localparam int ADDR_W       = 3 * AXIS_W;
    localparam int GRID_DEPTH   = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
    // Interpolated values may overshoot the sample range a little.
    localparam int VAL_W        = DENSITY_BITS + 4;
    // Width of the cubic coefficients.
    localparam int COEF_W       = VAL_W + 5;
    localparam int PROD_W       = COEF_W + 17;

    localparam logic [1:0] MODE_NEAREST = 2'd0;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_CUBIC   = 2'd2;

    localparam logic [1:0] PLANE_AC = 2'd1;
    localparam logic [1:0] PLANE_BC = 2'd2;

    typedef struct packed {
        logic [1:0]         interp_mode;
        logic [1:0]         projection_plane;
        logic signed [17:0] slice_level;
        logic [6:0]         size_x;
        logic [6:0]         size_y;
        logic [6:0]         size_z;
        logic [24:0]        inverse_range;
        logic [10:0]        lut_size;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic linear;
    } interp_req_t;

endpackage

FILE: rtl/core/pvs_grid_mem.sv
// Density grid storage: one write port, one registered read port.
module pvs_grid_mem (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [pvs_pkg::ADDR_W-1:0]           wr_addr,
    input  logic [pvs_pkg::DENSITY_BITS-1:0]     wr_data,
    input  logic                                 rd_en,
    input  logic [pvs_pkg::ADDR_W-1:0]           rd_addr,
    output logic [pvs_pkg::DENSITY_BITS-1:0]     rd_data
);

    logic [pvs_pkg::DENSITY_BITS-1:0] grid_mem [pvs_pkg::GRID_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= grid_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/pvs_interp.sv
// Shared linear / Catmull-Rom step unit with one multiplier used in turns.
module pvs_interp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  pvs_pkg::interp_req_t                   req,
    input  logic signed [pvs_pkg::VAL_W-1:0]       pin [4],
    input  logic [15:0]                            t_in,
    output logic                                   done,
    output logic signed [pvs_pkg::VAL_W-1:0]       result
);

    localparam int VW = pvs_pkg::VAL_W;
    localparam int AW = pvs_pkg::COEF_W;
    localparam int PW = pvs_pkg::PROD_W;
    localparam logic signed [PW-1:0] HALF16 = PW'(1) <<< 15;
    localparam logic signed [PW-1:0] HALF17 = PW'(1) <<< 16;

    typedef enum logic [2:0] {
        I_IDLE, I_MA, I_B, I_MB, I_C, I_MC, I_OUT
    } istate_t;

    istate_t               state_reg;
    logic signed [AW-1:0]  coef_reg, bcoef_reg, ccoef_reg;
    logic signed [VW-1:0]  base_reg;
    logic signed [PW-1:0]  prod_reg;
    logic [15:0]           t_reg;
    logic                  lin_reg;

    logic signed [AW-1:0]  e0, e1, e2, e3;
    logic signed [PW-1:0]  prod_w, rnd16_w, rnd17_w;

    assign e0 = AW'(pin[0]);
    assign e1 = AW'(pin[1]);
    assign e2 = AW'(pin[2]);
    assign e3 = AW'(pin[3]);
    assign prod_w  = coef_reg * $signed({1'b0, t_reg});
    assign rnd16_w = (prod_reg + HALF16) >>> 16;
    assign rnd17_w = (prod_reg + HALF17) >>> 17;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= I_IDLE;
            done      <= 1'b0;
        end else begin
            done <= (state_reg == I_OUT);
            case (state_reg)
                I_IDLE: begin
                    if (req.start) begin
                        t_reg   <= t_in;
                        lin_reg <= req.linear;
                        if (req.linear) begin
                            coef_reg <= e1 - e0;
                            base_reg <= pin[0];
                        end else begin
                            coef_reg  <= ((e1 - e2) <<< 1) + (e1 - e2) + e3 - e0;
                            bcoef_reg <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
                            ccoef_reg <= e2 - e0;
                            base_reg  <= pin[1];
                        end
                        state_reg <= I_MA;
                    end
                end
                I_MA: begin
                    prod_reg  <= prod_w;
                    state_reg <= lin_reg ? I_OUT : I_B;
                end
                I_B: begin
                    coef_reg  <= bcoef_reg + rnd16_w[AW-1:0];
                    state_reg <= I_MB;
                end
                I_MB: begin
                    prod_reg  <= prod_w;
                    state_reg <= I_C;
                end
                I_C: begin
                    coef_reg  <= ccoef_reg + rnd16_w[AW-1:0];
                    state_reg <= I_MC;
                end
                I_MC: begin
                    prod_reg  <= prod_w;
                    state_reg <= I_OUT;
                end
                I_OUT: begin
                    result    <= base_reg + (lin_reg ? rnd16_w[VW-1:0] : rnd17_w[VW-1:0]);
                    state_reg <= I_IDLE;
                end
                default: state_reg <= I_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/pvs_ctrl.sv
// Query sequencer: grid addressing, interpolation levels, colour index and result register.
`include "periodic_volume_sampler_unit_macros.svh"
module pvs_ctrl (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  pvs_pkg::cfg_t                          cfg,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [87:0]                            s_tdata,
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [47:0]                            m_tdata,
    output logic                                   m_tuser,
    output logic                                   mem_wr_en,
    output logic [pvs_pkg::ADDR_W-1:0]             mem_wr_addr,
    output logic [pvs_pkg::DENSITY_BITS-1:0]       mem_wr_data,
    output logic                                   mem_rd_en,
    output logic [pvs_pkg::ADDR_W-1:0]             mem_rd_addr,
    input  logic [pvs_pkg::DENSITY_BITS-1:0]       mem_rd_data,
    output pvs_pkg::interp_req_t                   ireq,
    output logic signed [pvs_pkg::VAL_W-1:0]       ipin [4],
    output logic [15:0]                            it,
    input  logic                                   idone,
    input  logic signed [pvs_pkg::VAL_W-1:0]       iresult
);

    localparam int VW = pvs_pkg::VAL_W;
    localparam int DB = pvs_pkg::DENSITY_BITS;
    localparam int XW = pvs_pkg::AXIS_W;
    localparam int RW = DB + 25;
    localparam int NW = 48;
    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
    localparam logic signed [VW-1:0] DMAX = VW'({1'b0, {(DB-1){1'b1}}});
    localparam logic signed [VW-1:0] DMIN = -DMAX - VW'(1);
    localparam logic signed [RW-1:0] PLIM = RW'(1) <<< 34;
    localparam logic signed [35:0] BIAS = 36'sd1 <<< 32;

    typedef enum logic [3:0] {
        C_IDLE, C_PREP, C_READ, C_DRAIN, C_RUN, C_WAIT, C_MAP0, C_MAP1, C_MAP2, C_OUT
    } cstate_t;

    function automatic logic [XW-1:0] wrap_idx(input logic [XW-1:0] base,
                                               input logic [1:0] cnt, input logic cub,
                                               input logic [6:0] sz);
        logic signed [8:0] s;
        logic signed [8:0] szs;
        begin
            szs = $signed({2'b00, sz});
            s = $signed({3'b000, base}) + $signed({7'b0, cnt}) - (cub ? 9'sd1 : 9'sd0);
            if (s < 0) begin
                s = s + szs;
            end else if (s >= szs) begin
                s = s - szs;
            end
            return s[XW-1:0];
        end
    endfunction

    function automatic logic [6:0] eff_size(input logic [6:0] s);
        begin
            if (s == 7'd0) return 7'd1;
            if (s > 7'(pvs_pkg::GRID_DIM_MAX)) return 7'(pvs_pkg::GRID_DIM_MAX);
            return s;
        end
    endfunction

    cstate_t               state_reg;
    logic signed [17:0]    u_reg, v_reg;
    logic [XW-1:0]         base_reg [3];
    logic [15:0]           t_reg [3];
    logic [1:0]            i_reg, j_reg, m_reg, lvl_reg;
    logic                  rd_pend_reg;
    logic [1:0]            rd_slot_reg;
    logic signed [VW-1:0]  zbuf_reg [4];
    logic signed [VW-1:0]  ybuf_reg [4];
    logic signed [VW-1:0]  xbuf_reg [4];
    logic signed [VW-1:0]  dval_reg;
    logic signed [DB-1:0]  dsat_reg;
    logic signed [RW-1:0]  prod_reg;
    logic signed [NW-1:0]  num_reg;
    logic                  skip_reg;
    logic                  m_tvalid_reg;
    logic [47:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    logic [6:0]            sz [3];
    logic [10:0]           lut_eff;
    logic                  cubic, linear;
    logic [1:0]            last_cnt;
    logic signed [17:0]    f [3];
    logic                  outside, upper;
    logic [22:0]           pos [3];
    logic [6:0]            near [3];
    logic [XW-1:0]         base_w [3];
    logic signed [VW-1:0]  rd_sext;
    logic signed [35:0]    pclamp;
    logic signed [14:0]    idx_raw;
    logic [9:0]            idx;
    logic                  accept;

    assign sz[0]   = eff_size(cfg.size_x);
    assign sz[1]   = eff_size(cfg.size_y);
    assign sz[2]   = eff_size(cfg.size_z);
    assign lut_eff = (cfg.lut_size < 11'd2) ? 11'd2 :
                     (cfg.lut_size > 11'(pvs_pkg::LUT_MAX)) ? 11'(pvs_pkg::LUT_MAX) :
                     cfg.lut_size;
    assign cubic    = (cfg.interp_mode == pvs_pkg::MODE_CUBIC);
    assign linear   = (cfg.interp_mode == pvs_pkg::MODE_LINEAR);
    assign last_cnt = cubic ? 2'd3 : 2'd1;
    assign rd_sext  = VW'($signed(mem_rd_data));
    assign s_tready = (state_reg == C_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Load path: a sample goes straight into the grid.
    assign mem_wr_en   = accept && !s_tuser;
    assign mem_wr_addr = {s_tdata[17:12], s_tdata[11:6], s_tdata[5:0]};
    assign mem_wr_data = s_tdata[49:18];

    // Map the in-plane pair and the slice level onto the a, b, c axes.
    always_comb begin
        case (cfg.projection_plane)
            pvs_pkg::PLANE_AC: begin
                f[0] = u_reg; f[1] = cfg.slice_level; f[2] = v_reg;
            end
            pvs_pkg::PLANE_BC: begin
                f[0] = cfg.slice_level; f[1] = u_reg; f[2] = v_reg;
            end
            default: begin
                f[0] = u_reg; f[1] = v_reg; f[2] = cfg.slice_level;
            end
        endcase
        outside = 1'b0;
        upper   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (f[k] < 0 || f[k] > ONE_Q16) outside = 1'b1;
            if (f[k] == ONE_Q16) upper = 1'b1;
            pos[k]  = 23'(f[k][15:0]) * 23'(sz[k]);
            near[k] = 7'((pos[k] + 23'd32768) >> 16);
            if (cfg.interp_mode == pvs_pkg::MODE_NEAREST) begin
                base_w[k] = (near[k] >= sz[k]) ? '0 : near[k][XW-1:0];
            end else begin
                base_w[k] = pos[k][16+XW-1:16];
            end
        end
    end

    assign mem_rd_en   = (state_reg == C_READ);
    assign mem_rd_addr = {wrap_idx(base_reg[2], m_reg, cubic, sz[2]),
                          wrap_idx(base_reg[1], j_reg, cubic, sz[1]),
                          wrap_idx(base_reg[0], i_reg, cubic, sz[0])};

    always_comb begin
        ireq.start  = (state_reg == C_RUN);
        ireq.linear = linear;
        case (lvl_reg)
            2'd1: begin
                ipin = ybuf_reg; it = t_reg[1];
            end
            2'd2: begin
                ipin = xbuf_reg; it = t_reg[0];
            end
            default: begin
                ipin = zbuf_reg; it = t_reg[2];
            end
        endcase
    end

    // Colour index: clamp the scaled density, then floor and clamp the index.
    always_comb begin
        if (prod_reg > PLIM) begin
            pclamp = PLIM[35:0];
        end else if (prod_reg < -PLIM) begin
            pclamp = -PLIM[35:0];
        end else begin
            pclamp = prod_reg[35:0];
        end
        idx_raw = num_reg[NW-1:33];
        if (idx_raw < 0) begin
            idx = '0;
        end else if (idx_raw >= $signed({4'b0, lut_eff})) begin
            idx = 10'(lut_eff - 11'd1);
        end else begin
            idx = idx_raw[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= C_IDLE;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != C_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            rd_pend_reg <= (state_reg == C_READ);
            if (rd_pend_reg) begin
                zbuf_reg[rd_slot_reg] <= rd_sext;
            end
            case (state_reg)
                C_IDLE: begin
                    if (accept && s_tuser) begin
                        u_reg     <= $signed(s_tdata[67:50]);
                        v_reg     <= $signed(s_tdata[85:68]);
                        state_reg <= C_PREP;
                    end
                end
                C_PREP: begin
                    for (int k = 0; k < 3; k++) begin
                        base_reg[k] <= base_w[k];
                        t_reg[k]    <= pos[k][15:0];
                    end
                    i_reg    <= '0;
                    j_reg    <= '0;
                    m_reg    <= '0;
                    lvl_reg  <= '0;
                    skip_reg <= outside;
                    dval_reg <= '0;
                    if (outside || upper || !(cubic || linear ||
                        cfg.interp_mode == pvs_pkg::MODE_NEAREST)) begin
                        state_reg <= C_MAP0;
                    end else begin
                        state_reg <= C_READ;
                    end
                end
                C_READ: begin
                    rd_slot_reg <= m_reg;
                    if (cfg.interp_mode == pvs_pkg::MODE_NEAREST || m_reg == last_cnt) begin
                        m_reg     <= '0;
                        state_reg <= C_DRAIN;
                    end else begin
                        m_reg <= m_reg + 2'd1;
                    end
                end
                C_DRAIN: begin
                    if (cfg.interp_mode == pvs_pkg::MODE_NEAREST) begin
                        dval_reg  <= rd_sext;
                        state_reg <= C_MAP0;
                    end else begin
                        lvl_reg   <= 2'd0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN: begin
                    state_reg <= C_WAIT;
                end
                C_WAIT: begin
                    if (idone) begin
                        case (lvl_reg)
                            2'd0: begin
                                ybuf_reg[j_reg] <= iresult;
                                if (j_reg == last_cnt) begin
                                    j_reg     <= '0;
                                    lvl_reg   <= 2'd1;
                                    state_reg <= C_RUN;
                                end else begin
                                    j_reg     <= j_reg + 2'd1;
                                    state_reg <= C_READ;
                                end
                            end
                            2'd1: begin
                                xbuf_reg[i_reg] <= iresult;
                                if (i_reg == last_cnt) begin
                                    lvl_reg   <= 2'd2;
                                    state_reg <= C_RUN;
                                end else begin
                                    i_reg     <= i_reg + 2'd1;
                                    lvl_reg   <= 2'd0;
                                    state_reg <= C_READ;
                                end
                            end
                            default: begin
                                dval_reg  <= iresult;
                                state_reg <= C_MAP0;
                            end
                        endcase
                    end
                end
                C_MAP0: begin
                    if (dval_reg > DMAX) begin
                        dsat_reg <= DMAX[DB-1:0];
                    end else if (dval_reg < DMIN) begin
                        dsat_reg <= DMIN[DB-1:0];
                    end else begin
                        dsat_reg <= dval_reg[DB-1:0];
                    end
                    state_reg <= C_MAP1;
                end
                C_MAP1: begin
                    prod_reg  <= RW'(dsat_reg) * RW'($signed({1'b0, cfg.inverse_range}));
                    state_reg <= C_MAP2;
                end
                C_MAP2: begin
                    num_reg   <= NW'($signed({1'b0, lut_eff})) * NW'(pclamp + BIAS);
                    state_reg <= C_OUT;
                end
                C_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= skip_reg;
                        m_tdata_reg  <= {6'b0, (skip_reg ? 10'd0 : idx),
                                         (skip_reg ? {DB{1'b0}} : dsat_reg)};
                        state_reg    <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PVS_ASSERT_NEXT(a_query_starts, accept && s_tuser, state_reg == C_PREP, "query not started")
    `PVS_ASSERT_IMP(a_done_in_wait, idone, state_reg == C_WAIT, "step result while not waiting")
    `PVS_ASSERT_IMP(a_skip_zero, m_tvalid && m_tuser, m_tdata == 48'd0, "skipped result not zero")

endmodule

FILE: rtl/core/periodic_volume_sampler_unit.sv
// Top level of the periodic volume sampler: configuration registers and unit wiring.
//
// The input stream carries two kinds of transfer, chosen by s_tuser. A load
// (s_tuser low) writes one density sample into the grid, gives no result and
// leaves the block idle. A query (s_tuser high) gives two in-plane
// coordinates; the block places the point in the unit cell, samples the grid
// by nearest, trilinear or Catmull-Rom tricubic interpolation and returns the
// density and a colour table index as one transfer on the m_ side.
// One query is worked on at a time. Every grid read goes through the single
// read port of the grid memory, and all interpolation steps share one
// multiplier. A nearest query makes one grid read, a trilinear one makes 4
// bursts of two reads and 7 linear steps, and a tricubic one makes 16 bursts
// of four reads and 21 cubic steps; each query then goes through the colour
// mapping. Points outside the cell or on its upper face, and queries in the
// unused mode, skip the reads and the interpolation steps.
// The next transfer can be taken in the same cycle as the result is offered.
// The result sits in an output register, so the next item can be taken while
// an earlier result waits; a stalled receiver holds a finished query until the
// register is free. Reset clears the control state and presets the configuration
// registers; the grid holds no reset value and must be loaded before use.
module periodic_volume_sampler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // grid_x[5:0], grid_y[11:6], grid_z[17:12], density[49:18],
    // coord_u[67:50], coord_v[85:68], zero fill above
    input  logic [87:0] s_tdata,
    // action[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // density_value[31:0], lut_index[41:32], zero fill above
    output logic [47:0] m_tdata,
    // skipped[0]
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register indexes, at byte offset four times the index.
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_PLANE = 3'd1;
    localparam logic [2:0] REG_SLICE = 3'd2;
    localparam logic [2:0] REG_SX    = 3'd3;
    localparam logic [2:0] REG_SY    = 3'd4;
    localparam logic [2:0] REG_SZ    = 3'd5;
    localparam logic [2:0] REG_INV   = 3'd6;
    localparam logic [2:0] REG_LUT   = 3'd7;

    pvs_pkg::cfg_t          cfg_reg;
    logic                   wr_en;
    logic                   mem_wr_en, mem_rd_en;
    logic [pvs_pkg::ADDR_W-1:0]         mem_wr_addr, mem_rd_addr;
    logic [pvs_pkg::DENSITY_BITS-1:0]   mem_wr_data, mem_rd_data;
    pvs_pkg::interp_req_t   ireq;
    logic signed [pvs_pkg::VAL_W-1:0]   ipin [4];
    logic [15:0]            it;
    logic                   idone;
    logic signed [pvs_pkg::VAL_W-1:0]   iresult;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Registers are written only while the block is idle, as the user guarantees; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interp_mode      <= pvs_pkg::MODE_NEAREST;
            cfg_reg.projection_plane <= '0;
            cfg_reg.slice_level      <= '0;
            cfg_reg.size_x           <= 7'd64;
            cfg_reg.size_y           <= 7'd64;
            cfg_reg.size_z           <= 7'd64;
            cfg_reg.inverse_range    <= 25'd65536;
            cfg_reg.lut_size         <= 11'd256;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_MODE:  cfg_reg.interp_mode      <= pwdata[1:0];
                REG_PLANE: cfg_reg.projection_plane <= pwdata[1:0];
                REG_SLICE: cfg_reg.slice_level      <= $signed(pwdata[17:0]);
                REG_SX:    cfg_reg.size_x           <= pwdata[6:0];
                REG_SY:    cfg_reg.size_y           <= pwdata[6:0];
                REG_SZ:    cfg_reg.size_z           <= pwdata[6:0];
                REG_INV:   cfg_reg.inverse_range    <= pwdata[24:0];
                REG_LUT:   cfg_reg.lut_size         <= pwdata[10:0];
                default:   cfg_reg.lut_size         <= cfg_reg.lut_size;
            endcase
        end
    end

    // The slice level reads back sign-extended.
    always_comb begin
        case (paddr[4:2])
            REG_MODE:  prdata = {30'b0, cfg_reg.interp_mode};
            REG_PLANE: prdata = {30'b0, cfg_reg.projection_plane};
            REG_SLICE: prdata = 32'(cfg_reg.slice_level);
            REG_SX:    prdata = {25'b0, cfg_reg.size_x};
            REG_SY:    prdata = {25'b0, cfg_reg.size_y};
            REG_SZ:    prdata = {25'b0, cfg_reg.size_z};
            REG_INV:   prdata = {7'b0, cfg_reg.inverse_range};
            REG_LUT:   prdata = {21'b0, cfg_reg.lut_size};
            default:   prdata = '0;
        endcase
    end

    pvs_grid_mem u_grid (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    pvs_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ireq),
        .pin     (ipin),
        .t_in    (it),
        .done    (idone),
        .result  (iresult)
    );

    pvs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .ireq        (ireq),
        .ipin        (ipin),
        .it          (it),
        .idone       (idone),
        .iresult     (iresult)
    );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the periodic volume sampler: stream stimulus, a predictor and a checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes. Each register sits at byte address 4 * index.
    localparam int REG_MODE  = 0;
    localparam int REG_PLANE = 1;
    localparam int REG_SLICE = 2;
    localparam int REG_SX    = 3;
    localparam int REG_SY    = 4;
    localparam int REG_SZ    = 5;
    localparam int REG_INV   = 6;
    localparam int REG_LUT   = 7;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] PLANE_AB    = 2'd0;
    localparam logic [1:0] PLANE_ALIAS = 2'd3;
    localparam logic       ACT_LOAD    = 1'b0;
    localparam logic       ACT_QUERY   = 1'b1;

    localparam longint ONE_Q16 = 65536;
    // Settle time after the stream drains, enough to cover a tricubic query with margin.
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        logic               action;
        logic [5:0]         gx;
        logic [5:0]         gy;
        logic [5:0]         gz;
        logic signed [31:0] density;
        logic signed [17:0] u;
        logic signed [17:0] v;
    } stream_item_t;

    typedef struct packed {
        logic               skipped;
        logic signed [31:0] density;
        logic [9:0]         lut_index;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    periodic_volume_sampler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the block's configuration and grid.
    pvs_pkg::cfg_t      cfg;
    logic signed [31:0] grid_shadow [pvs_pkg::GRID_DEPTH];
    bit                 grid_loaded [pvs_pkg::GRID_DEPTH];

    stream_item_t item_q[$];
    pixel_t       pixel_q[$];
    stream_item_t cur_item;

    int  mismatches = 0;
    bit  no_idle = 1'b0;
    bit  hold_start = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_cnt = 0;
    int  src_gap = 0;
    int  sink_gap = 0;

    function automatic int grid_addr(int a, int b, int c);
        return (c * pvs_pkg::GRID_DIM_MAX + b) * pvs_pkg::GRID_DIM_MAX + a;
    endfunction

    function automatic int axis_len(logic [6:0] s);
        if (s == 0) return 1;
        if (s > pvs_pkg::GRID_DIM_MAX) return pvs_pkg::GRID_DIM_MAX;
        return int'(s);
    endfunction

    function automatic int wrap_idx(int i, int sz);
        if (i < 0) i += sz;
        if (i >= sz) i -= sz;
        return i;
    endfunction

    // floor((x + 2^(k-1)) / 2^k); arithmetic shift on a longint is a floor.
    function automatic longint round_shift(longint x, int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint lerp(longint p0, longint p1, longint t);
        return p0 + round_shift((p1 - p0) * t, 16);
    endfunction

    function automatic longint catmull(longint p0, longint p1, longint p2, longint p3,
                                       longint t);
        longint ca, cb, cc;
        ca = 3 * (p1 - p2) + p3 - p0;
        cb = 2 * p0 - 5 * p1 + 4 * p2 - p3 + round_shift(ca * t, 16);
        cc = p2 - p0 + round_shift(cb * t, 16);
        return p1 + round_shift(cc * t, 17);
    endfunction

    function automatic longint cell_val(int a, int b, int c);
        return longint'(grid_shadow[grid_addr(a, b, c)]);
    endfunction

    // Interpolated density at a point in the unit cell that is not on an upper face.
    function automatic longint interp_density(longint f [3]);
        int     sz [3];
        int     base [3];
        longint t [3];
        longint pos, z0, z1;
        longint xa [4];
        longint yb [4];
        longint zc [4];
        longint ya [2];
        int     ia, b1, c1, ib;
        sz[0] = axis_len(cfg.size_x);
        sz[1] = axis_len(cfg.size_y);
        sz[2] = axis_len(cfg.size_z);
        for (int k = 0; k < 3; k++) begin
            pos = f[k] * sz[k];
            if (cfg.interp_mode == pvs_pkg::MODE_NEAREST) begin
                base[k] = int'((pos + 32768) >>> 16);
                if (base[k] >= sz[k]) base[k] = 0;
            end else begin
                base[k] = int'(pos >>> 16);
            end
            t[k] = pos & 64'hFFFF;
        end
        case (cfg.interp_mode)
            pvs_pkg::MODE_NEAREST: return cell_val(base[0], base[1], base[2]);
            pvs_pkg::MODE_LINEAR: begin
                b1 = wrap_idx(base[1] + 1, sz[1]);
                c1 = wrap_idx(base[2] + 1, sz[2]);
                for (int i = 0; i < 2; i++) begin
                    ia = wrap_idx(base[0] + i, sz[0]);
                    z0 = lerp(cell_val(ia, base[1], base[2]), cell_val(ia, base[1], c1), t[2]);
                    z1 = lerp(cell_val(ia, b1, base[2]), cell_val(ia, b1, c1), t[2]);
                    ya[i] = lerp(z0, z1, t[1]);
                end
                return lerp(ya[0], ya[1], t[0]);
            end
            pvs_pkg::MODE_CUBIC: begin
                for (int i = 0; i < 4; i++) begin
                    ia = wrap_idx(base[0] + i - 1, sz[0]);
                    for (int j = 0; j < 4; j++) begin
                        ib = wrap_idx(base[1] + j - 1, sz[1]);
                        for (int m = 0; m < 4; m++)
                            zc[m] = cell_val(ia, ib, wrap_idx(base[2] + m - 1, sz[2]));
                        yb[j] = catmull(zc[0], zc[1], zc[2], zc[3], t[2]);
                    end
                    xa[i] = catmull(yb[0], yb[1], yb[2], yb[3], t[1]);
                end
                return catmull(xa[0], xa[1], xa[2], xa[3], t[0]);
            end
            default: return 0;
        endcase
    endfunction

    // Full result of one query: placement, sampling, saturation and colour index.
    function automatic pixel_t shade_query(stream_item_t it);
        pixel_t px;
        longint f [3];
        longint s, d, lutn, lim, prod, idx;
        bit     upper;
        px = '0;
        upper = 1'b0;
        s = longint'(cfg.slice_level);
        case (cfg.projection_plane)
            pvs_pkg::PLANE_AC: begin f[0] = it.u; f[1] = s; f[2] = it.v; end
            pvs_pkg::PLANE_BC: begin f[0] = s; f[1] = it.u; f[2] = it.v; end
            default:  begin f[0] = it.u; f[1] = it.v; f[2] = s; end
        endcase
        for (int k = 0; k < 3; k++) begin
            if (f[k] < 0 || f[k] > ONE_Q16) begin
                px.skipped = 1'b1;
                return px;
            end
            if (f[k] == ONE_Q16) upper = 1'b1;
        end
        d = upper ? 0 : interp_density(f);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        lutn = cfg.lut_size;
        if (lutn < 2) lutn = 2;
        if (lutn > pvs_pkg::LUT_MAX) lutn = pvs_pkg::LUT_MAX;
        if (cfg.inverse_range == 0) begin
            prod = 0;
        end else begin
            lim = (longint'(1) <<< 34) / longint'(cfg.inverse_range);
            if (d > lim) prod = longint'(1) <<< 34;
            else if (d < -lim) prod = -(longint'(1) <<< 34);
            else prod = d * longint'(cfg.inverse_range);
        end
        idx = (lutn * ((longint'(1) <<< 32) + prod)) >>> 33;
        if (idx >= lutn) idx = lutn - 1;
        if (idx < 0) idx = 0;
        px.density = d[31:0];
        px.lut_index = idx[9:0];
        return px;
    endfunction

    // Source side: hands out queued items with random bursts of idle cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                // The shadow grid follows loads in stream order, queries see it as the block does.
                if (cur_item.action == ACT_LOAD) begin
                    grid_shadow[grid_addr(cur_item.gx, cur_item.gy, cur_item.gz)] =
                        cur_item.density;
                end else begin
                    pixel_q.push_back(shade_query(cur_item));
                end
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 16);
                    s_tvalid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    cur_item = item_q.pop_front();
                    s_tdata <= {2'b00, cur_item.v, cur_item.u, cur_item.density,
                                cur_item.gz, cur_item.gy, cur_item.gx};
                    s_tuser <= cur_item.action;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: checks each transfer against the oldest prediction and drives m_tready.
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: user=%0b data=%h", m_tuser, m_tdata);
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tuser !== want.skipped || m_tdata[31:0] !== want.density ||
                        m_tdata[41:32] !== want.lut_index || m_tdata[47:42] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected skip=%0b dens=%0d lut=%0d, got skip=%0b dens=%0d lut=%0d",
                                     want.skipped, want.density, want.lut_index, m_tuser,
                                     $signed(m_tdata[31:0]), m_tdata[41:32]);
                    end
                end
            end
            // One long stall lets the block fill up and push back on its input.
            if (hold_start && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt = 1500;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(int index, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(4 * index);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_MODE:  cfg.interp_mode = value[1:0];
            REG_PLANE: cfg.projection_plane = value[1:0];
            REG_SLICE: cfg.slice_level = value[17:0];
            REG_SX:    cfg.size_x = value[6:0];
            REG_SY:    cfg.size_y = value[6:0];
            REG_SZ:    cfg.size_z = value[6:0];
            REG_INV:   cfg.inverse_range = value[24:0];
            default:   cfg.lut_size = value[10:0];
        endcase
    endtask

    function automatic logic signed [31:0] rand_density();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic logic signed [17:0] rand_coord();
        case ($urandom_range(0, 11))
            0:       return 18'($urandom);
            1:       return 18'(ONE_Q16);
            2:       return 18'sd0;
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic push_load(int a, int b, int c, logic signed [31:0] dens);
        stream_item_t it;
        it = '0;
        it.action = ACT_LOAD;
        it.gx = 6'(a);
        it.gy = 6'(b);
        it.gz = 6'(c);
        it.density = dens;
        it.u = 18'($urandom);
        it.v = 18'($urandom);
        grid_loaded[grid_addr(a, b, c)] = 1'b1;
        item_q.push_back(it);
    endtask

    task automatic push_query(logic signed [17:0] u, logic signed [17:0] v);
        stream_item_t it;
        it = '0;
        it.action = ACT_QUERY;
        it.gx = 6'($urandom);
        it.gy = 6'($urandom);
        it.gz = 6'($urandom);
        it.density = $urandom;
        it.u = u;
        it.v = v;
        item_q.push_back(it);
    endtask

    // Waits for the stream to drain and every result to arrive, then for the block to settle.
    task automatic drain();
        int guard;
        do @(posedge aclk);
        while (item_q.size() != 0 || s_tvalid || pixel_q.size() != 0);
        guard = 0;
        while (guard < SETTLE_CYCLES) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // One phase: full register set, loads covering the active region, then a mix of transfers.
    task automatic run_phase(logic [1:0] mode, logic [1:0] plane, logic [17:0] slice,
                             logic [6:0] sx, logic [6:0] sy, logic [6:0] sz,
                             logic [24:0] inv, logic [10:0] lutn, int nquery);
        int ex, ey, ez;
        int lx, ly, lz;
        reg_write(REG_MODE, 32'(mode));
        reg_write(REG_PLANE, 32'(plane));
        reg_write(REG_SLICE, 32'(slice));
        reg_write(REG_SX, 32'(sx));
        reg_write(REG_SY, 32'(sy));
        reg_write(REG_SZ, 32'(sz));
        reg_write(REG_INV, 32'(inv));
        reg_write(REG_LUT, 32'(lutn));
        ex = axis_len(sx);
        ey = axis_len(sy);
        ez = axis_len(sz);
        // A cubic step on a one-point axis also reads index one, so two points are loaded.
        lx = (ex < 2) ? 2 : ex;
        ly = (ey < 2) ? 2 : ey;
        lz = (ez < 2) ? 2 : ez;
        // Every entry that a query may read is loaded first.
        for (int c = 0; c < lz; c++)
            for (int b = 0; b < ly; b++)
                for (int a = 0; a < lx; a++)
                    if (!grid_loaded[grid_addr(a, b, c)])
                        push_load(a, b, c, rand_density());
        for (int n = 0; n < nquery; n++) begin
            case ($urandom_range(0, 7))
                0: push_load($urandom_range(0, ex - 1), $urandom_range(0, ey - 1),
                             $urandom_range(0, ez - 1), rand_density());
                1: push_load($urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 63), rand_density());
                default: ;
            endcase
            push_query(rand_coord(), rand_coord());
        end
        drain();
    endtask

    initial begin
        int pick;
        logic [6:0] dims [3];
        cfg = '0;
        cfg.size_x = 7'd64;
        cfg.size_y = 7'd64;
        cfg.size_z = 7'd64;
        cfg.inverse_range = 25'd65536;
        cfg.lut_size = 11'd256;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed start: field extremes, faces of the cell, points just outside it.
        reg_write(REG_SX, 32'd2);
        reg_write(REG_SY, 32'd2);
        reg_write(REG_SZ, 32'd2);
        push_load(0, 0, 0, 32'sh7FFFFFFF);
        push_load(1, 0, 0, 32'sh80000000);
        push_load(0, 1, 0, 32'sd65536);
        push_load(1, 1, 0, -32'sd65536);
        push_load(0, 0, 1, 32'sd0);
        push_load(1, 0, 1, 32'sd1);
        push_load(0, 1, 1, -32'sd1);
        push_load(1, 1, 1, 32'sd123456);
        push_load(63, 63, 63, 32'sh7FFFFFFF);
        push_query(18'sd0, 18'sd0);
        push_query(18'sd49152, 18'sd16384);
        push_query(18'sd65535, 18'sd65535);
        push_query(18'(ONE_Q16), 18'sd100);
        push_query(18'sd100, 18'(ONE_Q16));
        push_query(-18'sd1, 18'sd0);
        push_query(18'sd65537, 18'sd0);
        push_query(18'sh1FFFF, 18'sd5);
        push_query(18'sh20000, 18'sh1FFFF);
        push_query(18'sd5, 18'sh20000);
        push_query(18'sd32768, 18'sd32768);
        drain();

        // Named corner settings: unused codes, zero and oversize grids, LUT and range extremes.
        run_phase(pvs_pkg::MODE_LINEAR, pvs_pkg::PLANE_AC, 18'sd32768, 7'd3, 7'd5, 7'd2,
                  25'd1, 11'd2, 25);
        run_phase(pvs_pkg::MODE_CUBIC, pvs_pkg::PLANE_BC, 18'sd16000, 7'd4, 7'd4, 7'd4,
                  25'h1000000, 11'd1024, 25);
        run_phase(MODE_UNUSED, PLANE_ALIAS, 18'sd100, 7'd2, 7'd2, 7'd2, 25'd0, 11'd0, 15);
        run_phase(pvs_pkg::MODE_NEAREST, PLANE_AB, 18'(ONE_Q16), 7'd0, 7'd127, 7'd1,
                  25'h1FFFFFF, 11'd2047, 25);
        run_phase(pvs_pkg::MODE_CUBIC, PLANE_AB, 18'sh20000, 7'd1, 7'd1, 7'd64, 25'd65536,
                  11'd1, 10);
        run_phase(pvs_pkg::MODE_CUBIC, pvs_pkg::PLANE_AC, 18'sh1FFFF, 7'd64, 7'd1, 7'd1,
                  25'd65536, 11'd3, 10);

        // Long receiver stall while the source keeps offering queries.
        hold_start <= 1'b1;
        run_phase(pvs_pkg::MODE_NEAREST, PLANE_AB, 18'sd0, 7'd4, 7'd4, 7'd4, 25'd65536,
                  11'd256, 40);

        for (int p = 0; p < 16; p++) begin
            if (p >= 13) no_idle = 1'b1;
            for (int k = 0; k < 3; k++) begin
                pick = $urandom_range(0, 9);
                dims[k] = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom_range(1, 6));
            end
            // Keep one axis at the full size now and then, the others at one.
            if ($urandom_range(0, 4) == 0) begin
                dims[0] = 7'd1;
                dims[1] = 7'd1;
                dims[2] = 7'd1;
                dims[$urandom_range(0, 2)] = 7'd64;
            end else begin
                for (int k = 0; k < 3; k++)
                    if (dims[k] == 7'd127) dims[k] = 7'd1;
            end
            run_phase(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      ($urandom_range(0, 7) == 0) ? 18'($urandom) : 18'($urandom_range(0, 65536)),
                      dims[0], dims[1], dims[2],
                      ($urandom_range(0, 3) == 0) ? 25'($urandom) : 25'($urandom_range(1, 1 << 18)),
                      11'($urandom_range(0, 2047)), 45);
        end

        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
